// ===== hdl/mlfd_pkg.sv =====
// Package for the marker/length frame deframer.
// Holds the parser phase type, word kind codes, register indexes and the
// config and result structs shared by the core and the parser.
`timescale 1ns / 1ps

package mlfd_pkg;

   // Field widths of the byte stream and of the result word.
   localparam int unsigned ByteW  = 8;
   localparam int unsigned LenW   = 16;
   localparam int unsigned KindW  = 3;
   localparam int unsigned CsrIdxW = 3;
   localparam int unsigned CsrDataW = 16;

   // Kind of each result word.
   localparam logic [KindW-1:0] KIND_NONE   = 3'd0;
   localparam logic [KindW-1:0] KIND_DATA   = 3'd1;
   localparam logic [KindW-1:0] KIND_GOOD   = 3'd2;
   localparam logic [KindW-1:0] KIND_BADEND = 3'd3;
   localparam logic [KindW-1:0] KIND_REJECT = 3'd4;

   // Configuration register indexes.
   localparam logic [CsrIdxW-1:0] REG_START_ONE = 3'd0;
   localparam logic [CsrIdxW-1:0] REG_START_TWO = 3'd1;
   localparam logic [CsrIdxW-1:0] REG_END_ONE   = 3'd2;
   localparam logic [CsrIdxW-1:0] REG_END_TWO   = 3'd3;
   localparam logic [CsrIdxW-1:0] REG_MAX_LEN   = 3'd4;

   // Register reset values.
   localparam logic [ByteW-1:0] RST_START_ONE = 8'd170;
   localparam logic [ByteW-1:0] RST_START_TWO = 8'd85;
   localparam logic [ByteW-1:0] RST_END_ONE   = 8'd85;
   localparam logic [ByteW-1:0] RST_END_TWO   = 8'd170;
   localparam logic [LenW-1:0]  RST_MAX_LEN   = 16'd1024;

   // Parser phase.
   typedef enum logic [2:0] {
      PH_HUNT_ONE = 3'd0,
      PH_HUNT_TWO = 3'd1,
      PH_LEN_LO   = 3'd2,
      PH_LEN_HI   = 3'd3,
      PH_PAYLOAD  = 3'd4,
      PH_END      = 3'd5
   } phase_type;

   // Marker and limit settings handed to the parser.
   typedef struct packed {
      logic [ByteW-1:0] start_one;
      logic [ByteW-1:0] start_two;
      logic [ByteW-1:0] end_one;
      logic [ByteW-1:0] end_two;
      logic [LenW-1:0]  max_len;
   } cfg_type;

   // One result word.
   typedef struct packed {
      logic [KindW-1:0] kind;
      logic [ByteW-1:0] data;
      logic [LenW-1:0]  length;
   } result_type;

endpackage

// ===== hdl/marker_length_frame_deframer_core.sv =====
// Top level of the marker/length frame deframer.
// Holds the input and result registers and the configuration registers.
// Depends on mlfd_pkg and mlfd_parse.
`timescale 1ns / 1ps

// Usage:
// The req_ stream carries one received byte per word. For every byte taken
// the rsp_ stream returns exactly one word: its kind (nothing, payload byte,
// frame good, bad end marker, length rejected) in rsp_tuser and the payload
// byte and frame length in rsp_tdata. The consumer drops the payload bytes
// of a frame whose end word reports a bad end marker or a rejected length.
// The csr_ port writes the start markers, end markers and length limit;
// write it only while no byte is in flight.
// Timing: a taken byte is held in the input register, parsed, and its
// result is loaded into the result register once that register is free,
// which drives rsp_. Throughput is one byte per cycle while rsp_tready
// keeps the result register free, set by the combinational parse between
// the input and result registers. When rsp_tready is low the result
// register holds and the input register still takes one more byte before
// req_tready drops.
// Reset clears both registers, returns the parser to hunting for the first
// start byte and loads the default markers and limit.

module marker_length_frame_deframer_core (
   input  logic                                clock,
   input  logic                                reset,
   // Byte stream in.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [mlfd_pkg::ByteW-1:0]          req_tdata,   // [7:0] in_byte
   // Result stream out.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [mlfd_pkg::ByteW+mlfd_pkg::LenW-1:0] rsp_tdata, // [7:0] out_data,
                                                               // [23:8] frame_length
   output logic [mlfd_pkg::KindW-1:0]          rsp_tuser,   // [2:0] out_kind
   // Configuration writes.
   input  logic                                csr_we,
   input  logic [mlfd_pkg::CsrIdxW-1:0]        csr_index,
   input  logic [mlfd_pkg::CsrDataW-1:0]       csr_wdata
);

   logic                          in_valid_ff;
   logic [mlfd_pkg::ByteW-1:0]    in_byte_ff;
   logic                          out_valid_ff;
   mlfd_pkg::result_type          out_ff;
   mlfd_pkg::result_type          result;
   mlfd_pkg::cfg_type             cfg_ff;
   logic                          advance;

   // A held byte moves to the result register when that register is free.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
      end
   end

   // Parser.
   mlfd_parse u_parse (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .in_byte (in_byte_ff),
      .cfg     (cfg_ff),
      .result  (result)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tdata  = {out_ff.length, out_ff.data};

   // Configuration registers; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_one <= mlfd_pkg::RST_START_ONE;
         cfg_ff.start_two <= mlfd_pkg::RST_START_TWO;
         cfg_ff.end_one   <= mlfd_pkg::RST_END_ONE;
         cfg_ff.end_two   <= mlfd_pkg::RST_END_TWO;
         cfg_ff.max_len   <= mlfd_pkg::RST_MAX_LEN;
      end else if (csr_we) begin
         case (csr_index)
            mlfd_pkg::REG_START_ONE: cfg_ff.start_one <= csr_wdata[mlfd_pkg::ByteW-1:0];
            mlfd_pkg::REG_START_TWO: cfg_ff.start_two <= csr_wdata[mlfd_pkg::ByteW-1:0];
            mlfd_pkg::REG_END_ONE:   cfg_ff.end_one   <= csr_wdata[mlfd_pkg::ByteW-1:0];
            mlfd_pkg::REG_END_TWO:   cfg_ff.end_two   <= csr_wdata[mlfd_pkg::ByteW-1:0];
            mlfd_pkg::REG_MAX_LEN:   cfg_ff.max_len   <= csr_wdata[mlfd_pkg::LenW-1:0];
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

endmodule

// ===== hdl/mlfd_parse.sv =====
// Frame parser for the marker/length frame deframer.
// Holds the hunt/length/payload/end state and maps one byte to one result.
// Depends on mlfd_pkg.
`timescale 1ns / 1ps

module mlfd_parse (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic [mlfd_pkg::ByteW-1:0]    in_byte,
   input  mlfd_pkg::cfg_type             cfg,
   output mlfd_pkg::result_type          result
);

   mlfd_pkg::phase_type             phase_ff, phase_in;
   logic [mlfd_pkg::LenW-1:0]       payload_len_ff, payload_len_in;
   logic [mlfd_pkg::LenW-1:0]       bytes_left_ff, bytes_left_in;
   logic                            end_one_ff, end_one_in;
   logic [mlfd_pkg::LenW-1:0]       full_len;
   logic                            len_reject;

   // Full length once the high byte arrives, and the limit check.
   assign full_len   = {in_byte, payload_len_ff[mlfd_pkg::ByteW-1:0]};
   assign len_reject = (full_len >= cfg.max_len);

   // Next state.
   always_comb begin
      phase_in       = phase_ff;
      payload_len_in = payload_len_ff;
      bytes_left_in  = bytes_left_ff;
      end_one_in     = end_one_ff;
      case (phase_ff)
         mlfd_pkg::PH_HUNT_ONE: begin
            if (in_byte == cfg.start_one) begin
               phase_in = mlfd_pkg::PH_HUNT_TWO;
            end
         end
         mlfd_pkg::PH_HUNT_TWO: begin
            if (in_byte == cfg.start_two) begin
               phase_in = mlfd_pkg::PH_LEN_LO;
            end else if (in_byte != cfg.start_one) begin
               phase_in = mlfd_pkg::PH_HUNT_ONE;
            end
         end
         mlfd_pkg::PH_LEN_LO: begin
            payload_len_in = {{(mlfd_pkg::LenW-mlfd_pkg::ByteW){1'b0}}, in_byte};
            phase_in       = mlfd_pkg::PH_LEN_HI;
         end
         mlfd_pkg::PH_LEN_HI: begin
            payload_len_in = full_len;
            if (len_reject) begin
               phase_in = mlfd_pkg::PH_HUNT_ONE;
            end else begin
               bytes_left_in = full_len;
               end_one_in    = 1'b0;
               phase_in      = (full_len == '0) ? mlfd_pkg::PH_END : mlfd_pkg::PH_PAYLOAD;
            end
         end
         mlfd_pkg::PH_PAYLOAD: begin
            bytes_left_in = bytes_left_ff - {{(mlfd_pkg::LenW-1){1'b0}}, 1'b1};
            if (bytes_left_ff == {{(mlfd_pkg::LenW-1){1'b0}}, 1'b1}) begin
               end_one_in = 1'b0;
               phase_in   = mlfd_pkg::PH_END;
            end
         end
         mlfd_pkg::PH_END: begin
            if (!end_one_ff) begin
               if (in_byte == cfg.end_one) begin
                  end_one_in = 1'b1;
               end else begin
                  phase_in = mlfd_pkg::PH_HUNT_ONE;
               end
            end else begin
               end_one_in = 1'b0;
               phase_in   = mlfd_pkg::PH_HUNT_ONE;
            end
         end
         default: begin
            phase_in = mlfd_pkg::PH_HUNT_ONE;
         end
      endcase
   end

   // Result word for the current byte.
   always_comb begin
      result = '{kind: mlfd_pkg::KIND_NONE, data: '0, length: '0};
      case (phase_ff)
         mlfd_pkg::PH_LEN_HI: begin
            if (len_reject) begin
               result.kind   = mlfd_pkg::KIND_REJECT;
               result.length = full_len;
            end
         end
         mlfd_pkg::PH_PAYLOAD: begin
            result.kind = mlfd_pkg::KIND_DATA;
            result.data = in_byte;
         end
         mlfd_pkg::PH_END: begin
            if (!end_one_ff) begin
               if (in_byte != cfg.end_one) begin
                  result.kind   = mlfd_pkg::KIND_BADEND;
                  result.length = payload_len_ff;
               end
            end else begin
               result.kind   = (in_byte == cfg.end_two) ? mlfd_pkg::KIND_GOOD
                                                        : mlfd_pkg::KIND_BADEND;
               result.length = payload_len_ff;
            end
         end
         default: begin
            result.kind = mlfd_pkg::KIND_NONE;
         end
      endcase
   end

   // State registers advance once per processed byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= mlfd_pkg::PH_HUNT_ONE;
         payload_len_ff <= '0;
         bytes_left_ff  <= '0;
         end_one_ff     <= 1'b0;
      end else if (step) begin
         phase_ff       <= phase_in;
         payload_len_ff <= payload_len_in;
         bytes_left_ff  <= bytes_left_in;
         end_one_ff     <= end_one_in;
      end
   end

endmodule

// ===== tb/mlfd_result_monitor.sv =====
// Result monitor for the marker/length frame deframer testbench.
// Mirrors the CSR writes, predicts one result word per accepted byte and
// compares it with the rsp_ stream. Depends on mlfd_pkg.
`timescale 1ns / 1ps

module mlfd_result_monitor (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_tvalid,
   input  logic                                      req_tready,
   input  logic [mlfd_pkg::ByteW-1:0]                req_tdata,
   input  logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   input  logic [mlfd_pkg::ByteW+mlfd_pkg::LenW-1:0] rsp_tdata,
   input  logic [mlfd_pkg::KindW-1:0]                rsp_tuser,
   input  logic                                      csr_we,
   input  logic [mlfd_pkg::CsrIdxW-1:0]              csr_index,
   input  logic [mlfd_pkg::CsrDataW-1:0]             csr_wdata,
   output int                                        fail_count,
   output int                                        words_pending,
   output int                                        payload_words,
   output int                                        frames_good,
   output int                                        frames_bad,
   output int                                        frames_rejected
);

   import mlfd_pkg::*;

   // Keeps the log readable when the block is badly broken.
   localparam int ReportLimit = 100;

   // Shadow copy of the settings and of the parser state.
   cfg_type    settings;
   phase_type  parse_phase;
   logic [LenW-1:0] frame_len;
   logic [LenW-1:0] bytes_to_go;
   logic       end_one_seen;

   // Result words still owed by the block, oldest first.
   result_type expected_words[$];

   task automatic note_mismatch(input string field, input int want, input int got);
      if (fail_count < ReportLimit)
         $error("%s: expected %0d, actual %0d", field, want, got);
      fail_count++;
   endtask

   // Advances the shadow parser by one byte and queues the word it owes.
   task automatic parse_byte(input logic [ByteW-1:0] in_byte);
      result_type word;
      logic [LenW-1:0] len;
      word = '0;
      case (parse_phase)
         PH_HUNT_ONE: begin
            if (in_byte == settings.start_one)
               parse_phase = PH_HUNT_TWO;
         end
         PH_HUNT_TWO: begin
            // A repeated first marker byte keeps waiting for the second one.
            if (in_byte == settings.start_two)
               parse_phase = PH_LEN_LO;
            else if (in_byte != settings.start_one)
               parse_phase = PH_HUNT_ONE;
         end
         PH_LEN_LO: begin
            frame_len = {8'h00, in_byte};
            parse_phase = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            len = {in_byte, frame_len[ByteW-1:0]};
            frame_len = len;
            if (len >= settings.max_len) begin
               word.kind = KIND_REJECT;
               word.length = len;
               parse_phase = PH_HUNT_ONE;
            end else begin
               bytes_to_go = len;
               end_one_seen = 1'b0;
               if (len == '0)
                  parse_phase = PH_END;
               else
                  parse_phase = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            word.kind = KIND_DATA;
            word.data = in_byte;
            bytes_to_go = bytes_to_go - 1'b1;
            if (bytes_to_go == '0) begin
               end_one_seen = 1'b0;
               parse_phase = PH_END;
            end
         end
         PH_END: begin
            // The first mismatching end byte closes the frame as bad.
            if (!end_one_seen) begin
               if (in_byte == settings.end_one) begin
                  end_one_seen = 1'b1;
               end else begin
                  word.kind = KIND_BADEND;
                  word.length = frame_len;
                  parse_phase = PH_HUNT_ONE;
               end
            end else begin
               word.kind = (in_byte == settings.end_two) ? KIND_GOOD : KIND_BADEND;
               word.length = frame_len;
               end_one_seen = 1'b0;
               parse_phase = PH_HUNT_ONE;
            end
         end
         default: parse_phase = PH_HUNT_ONE;
      endcase
      expected_words.push_back(word);
   endtask

   // Everything is sampled at the rising edge, before the edge's updates land.
   always @(posedge clock) begin : watch
      result_type want;
      if (reset) begin
         settings = '{start_one: RST_START_ONE, start_two: RST_START_TWO,
                      end_one: RST_END_ONE, end_two: RST_END_TWO, max_len: RST_MAX_LEN};
         parse_phase = PH_HUNT_ONE;
         frame_len = '0;
         bytes_to_go = '0;
         end_one_seen = 1'b0;
         expected_words.delete();
         fail_count = 0;
         payload_words = 0;
         frames_good = 0;
         frames_bad = 0;
         frames_rejected = 0;
      end else begin
         // Register writes; unknown indexes are dropped.
         if (csr_we) begin
            case (csr_index)
               REG_START_ONE: settings.start_one = csr_wdata[ByteW-1:0];
               REG_START_TWO: settings.start_two = csr_wdata[ByteW-1:0];
               REG_END_ONE:   settings.end_one = csr_wdata[ByteW-1:0];
               REG_END_TWO:   settings.end_two = csr_wdata[ByteW-1:0];
               REG_MAX_LEN:   settings.max_len = csr_wdata[LenW-1:0];
               default: ;
            endcase
         end

         if (req_tvalid && req_tready)
            parse_byte(req_tdata);

         // Compare each delivered word with the oldest prediction.
         if (rsp_tvalid && rsp_tready) begin
            if (expected_words.size() == 0) begin
               note_mismatch("unexpected word out_kind", -1, rsp_tuser);
            end else begin
               want = expected_words.pop_front();
               if (rsp_tuser !== want.kind)
                  note_mismatch("out_kind", want.kind, rsp_tuser);
               if (rsp_tdata[ByteW-1:0] !== want.data)
                  note_mismatch("out_data", want.data, rsp_tdata[ByteW-1:0]);
               if (rsp_tdata[ByteW +: LenW] !== want.length)
                  note_mismatch("frame_length", want.length, rsp_tdata[ByteW +: LenW]);
               case (want.kind)
                  KIND_DATA:   payload_words++;
                  KIND_GOOD:   frames_good++;
                  KIND_BADEND: frames_bad++;
                  KIND_REJECT: frames_rejected++;
                  default: ;
               endcase
            end
         end
      end
      words_pending = expected_words.size();
   end

endmodule

// ===== tb/marker_length_frame_deframer_core_tb.sv =====
// Top of the marker/length frame deframer testbench.
// Drives directed and random byte streams, CSR settings and rsp_ back-pressure;
// checking is done by mlfd_result_monitor. Depends on mlfd_pkg and the core.
`timescale 1ns / 1ps

module marker_length_frame_deframer_core_tb;

   import mlfd_pkg::*;

   localparam int HalfPeriod    = 10;
   localparam int ResetCycles   = 11;
   localparam int BytesPerSet   = 160;
   localparam int SettingCount  = 6;
   localparam int SettleCycles  = 8;
   localparam int TimeoutCycles = 300000;
   // First index past the register list.
   localparam logic [CsrIdxW-1:0] REG_SPARE = REG_MAX_LEN + 3'd1;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [ByteW-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [ByteW+LenW-1:0] rsp_tdata;
   logic [KindW-1:0] rsp_tuser;
   logic csr_we = 1'b0;
   logic [CsrIdxW-1:0] csr_index = '0;
   logic [CsrDataW-1:0] csr_wdata = '0;

   int fail_count;
   int words_pending;
   int payload_words;
   int frames_good;
   int frames_bad;
   int frames_rejected;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int bytes_sent = 0;
   int cycle_count = 0;

   // Marker settings currently loaded, used to build frames.
   cfg_type cur_cfg = '{start_one: RST_START_ONE, start_two: RST_START_TWO,
                        end_one: RST_END_ONE, end_two: RST_END_TWO, max_len: RST_MAX_LEN};

   always begin
      #(HalfPeriod) clock = 1'b1;
      #(HalfPeriod) clock = 1'b0;
   end

   marker_length_frame_deframer_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [7:0] in_byte
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // [7:0] out_data, [23:8] frame_length
      .rsp_tuser  (rsp_tuser),   // [2:0] out_kind
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   mlfd_result_monitor u_monitor (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .words_pending   (words_pending),
      .payload_words   (payload_words),
      .frames_good     (frames_good),
      .frames_bad      (frames_bad),
      .frames_rejected (frames_rejected)
   );

   // Random back-pressure on the result side.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Hard stop in case the block hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= TimeoutCycles) begin
         $display("marker_length_frame_deframer_core_tb NOT OK");
         $finish;
      end
   end

   // Offers one byte, with random idle cycles first, and waits for acceptance.
   task automatic send_byte(input logic [ByteW-1:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= value;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_seq(input logic [ByteW-1:0] seq[$]);
      foreach (seq[i])
         send_byte(seq[i]);
   endtask

   // Stops sending and waits until every owed result word has been delivered.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (words_pending != 0)
         @(posedge clock);
   endtask

   task automatic write_reg(input logic [CsrIdxW-1:0] idx, input logic [CsrDataW-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_settings(input cfg_type cfg);
      write_reg(REG_START_ONE, {8'h00, cfg.start_one});
      write_reg(REG_START_TWO, {8'h00, cfg.start_two});
      write_reg(REG_END_ONE, {8'h00, cfg.end_one});
      write_reg(REG_END_TWO, {8'h00, cfg.end_two});
      write_reg(REG_MAX_LEN, cfg.max_len);
      cur_cfg = cfg;
   endtask

   // Mostly short payloads, now and then a longer one, always under the limit.
   function automatic logic [LenW-1:0] pick_length();
      int longest;
      int cap;
      longest = int'(cur_cfg.max_len) - 1;
      cap = ($urandom_range(19) == 0) ? 200 : 12;
      if (longest > cap)
         longest = cap;
      return LenW'($urandom_range(longest));
   endfunction

   task automatic send_header(input logic [LenW-1:0] len);
      // Sometimes lead with a repeated first start byte.
      if ($urandom_range(9) == 0)
         send_byte(cur_cfg.start_one);
      send_byte(cur_cfg.start_one);
      send_byte(cur_cfg.start_two);
      send_byte(len[7:0]);
      send_byte(len[15:8]);
   endtask

   // One random frame: good, bad end marker, rejected length, or line noise.
   task automatic send_random_frame();
      int pick;
      logic [LenW-1:0] len;
      logic [ByteW-1:0] flip;
      pick = $urandom_range(99);
      flip = ByteW'($urandom_range(255, 1));
      if (pick < 89 && pick >= 77) begin
         send_header(LenW'($urandom_range(65535, int'(cur_cfg.max_len))));
      end else if (pick < 77) begin
         len = pick_length();
         send_header(len);
         repeat (len)
            send_byte(ByteW'($urandom_range(255)));
         if (pick < 65) begin
            send_byte(cur_cfg.end_one);
            send_byte(cur_cfg.end_two);
         end else if ($urandom_range(1) == 0) begin
            send_byte(cur_cfg.end_one ^ flip);
         end else begin
            send_byte(cur_cfg.end_one);
            send_byte(cur_cfg.end_two ^ flip);
         end
      end else begin
         repeat ($urandom_range(6, 1))
            send_byte(ByteW'($urandom_range(255)));
      end
   endtask

   initial begin
      cfg_type cfg;
      int set_start;
      int idx;

      send_idle_pct = 35;
      recv_idle_pct = 69;
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed frames on the reset markers.
      // Repeated first start byte, one payload byte, good end.
      send_seq('{RST_START_ONE, RST_START_ONE, RST_START_TWO, 8'h01, 8'h00, 8'hFF,
                 RST_END_ONE, RST_END_TWO});
      // Zero length with a bad first end byte.
      send_seq('{RST_START_ONE, RST_START_TWO, 8'h00, 8'h00, 8'h12});
      // Largest length, then a length right at the limit: both rejected.
      send_seq('{RST_START_ONE, RST_START_TWO, 8'hFF, 8'hFF});
      send_seq('{RST_START_ONE, RST_START_TWO, 8'h00, 8'h04});

      // A zero limit rejects even an empty frame.
      drain_results();
      write_reg(REG_MAX_LEN, '0);
      send_seq('{RST_START_ONE, RST_START_TWO, 8'h00, 8'h00});

      // Writes past the register list must leave the settings alone.
      drain_results();
      write_reg(REG_MAX_LEN, RST_MAX_LEN);
      for (idx = int'(REG_SPARE); idx < (1 << CsrIdxW); idx++)
         write_reg(CsrIdxW'(idx), '0);
      send_seq('{RST_START_ONE, RST_START_TWO, 8'h01, 8'h00, 8'h00, RST_END_ONE, 8'h00});

      // Random frames under a series of settings and idle patterns.
      for (int set_no = 0; set_no < SettingCount; set_no++) begin
         drain_results();
         case (set_no / 2)
            0: begin
               send_idle_pct = 35;
               recv_idle_pct = 69;
            end
            1: begin
               send_idle_pct = 69;
               recv_idle_pct = 35;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         case (set_no)
            0: cfg = '{RST_START_ONE, RST_START_TWO, RST_END_ONE, RST_END_TWO, RST_MAX_LEN};
            1: cfg = '{8'h00, 8'h00, 8'h00, 8'h00, 16'd1};
            2: cfg = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF};
            4: cfg = '{8'h7E, 8'h7E, 8'h7E, 8'h7E, 16'd40};
            default: begin
               cfg.start_one = ByteW'($urandom_range(255));
               cfg.start_two = ByteW'($urandom_range(255));
               cfg.end_one = ByteW'($urandom_range(255));
               cfg.end_two = ByteW'($urandom_range(255));
               cfg.max_len = (set_no == 3) ? LenW'($urandom_range(64, 2))
                                           : LenW'($urandom_range(65535, 1));
            end
         endcase
         load_settings(cfg);
         set_start = bytes_sent;
         while (bytes_sent - set_start < BytesPerSet)
            send_random_frame();
      end

      drain_results();
      repeat (SettleCycles) @(posedge clock);

      $display("Sent %0d bytes over %0d marker settings plus directed frames.",
               bytes_sent, SettingCount);
      $display("Checked %0d payload words, %0d good, %0d bad-end and %0d rejected frames.",
               payload_words, frames_good, frames_bad, frames_rejected);
      if (fail_count == 0 && words_pending == 0)
         $display("marker_length_frame_deframer_core_tb OK");
      else
         $display("marker_length_frame_deframer_core_tb NOT OK");
      $finish;
   end

endmodule
